// ===== rtl/gvca_pkg.sv =====
// Shared types, codes and reset constants for the goal velocity command arbiter.
`default_nettype none

package gvca_pkg;

   // Input action codes.
   localparam logic [1:0] ACT_POSE    = 2'd0;
   localparam logic [1:0] ACT_GOAL    = 2'd1;
   localparam logic [1:0] ACT_PLANNER = 2'd2;
   localparam logic [1:0] ACT_TICK    = 2'd3;

   // Command source codes.
   localparam logic [1:0] SRC_HEARTBEAT = 2'd0;
   localparam logic [1:0] SRC_PLANNER   = 2'd1;
   localparam logic [1:0] SRC_GOAL_NAV  = 2'd2;
   localparam logic [1:0] SRC_GOAL_HOLD = 2'd3;

   // Register indexes of the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 21;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE_FLAGS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_XY         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPEED_XY    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_Z          = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPEED_Z     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_REACH_RADIUS_XY = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_REACH_RADIUS_Z  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANNER_TIMEOUT = 3'd7;

   // Mode flag bit positions.
   localparam int unsigned MODE_NAV_EN_BIT    = 0;
   localparam int unsigned MODE_HEARTBEAT_BIT = 1;

   // Goal height after reset: 5 m in Q16.16.
   localparam logic [31:0] GOAL_Z_RESET = 32'd327680;

   // Saturation value of the planner age counter.
   localparam logic [15:0] AGE_MAX = 16'hFFFF;

   typedef logic [2:0][31:0] vec3_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] val_x;
      logic signed [31:0] val_y;
      logic signed [31:0] val_z;
      logic signed [31:0] val_yaw_rate;
      logic               armed_offboard;
   } req_type;

   typedef struct packed {
      logic signed [31:0] cmd_vx;
      logic signed [31:0] cmd_vy;
      logic signed [31:0] cmd_vz;
      logic signed [31:0] cmd_yaw_rate;
      logic [1:0]         cmd_source;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  mode_flags;
      logic [15:0] gain_xy;
      logic [20:0] max_speed_xy;
      logic [15:0] gain_z;
      logic [20:0] max_speed_z;
      logic [20:0] reach_radius_xy;
      logic [20:0] reach_radius_z;
      logic [15:0] planner_timeout_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode_flags:            2'd3,
      gain_xy:               16'd205,
      max_speed_xy:          21'd65536,
      gain_z:                16'd205,
      max_speed_z:           21'd39322,
      reach_radius_xy:       21'd16384,
      reach_radius_z:        21'd13107,
      planner_timeout_ticks: 16'd6
   };

   // Outcome of one goal navigation pass: reached flag, magnitudes and signs per axis.
   typedef struct packed {
      logic        reached;
      logic        neg_x;
      logic        neg_y;
      logic        neg_z;
      logic [31:0] mag_x;
      logic [31:0] mag_y;
      logic [31:0] mag_z;
   } nav_result_type;

   typedef enum logic {
      T_IDLE,
      T_NAV
   } top_state_type;

   typedef enum logic [4:0] {
      N_IDLE,
      N_DIFF,
      N_R2,
      N_MX,
      N_MY,
      N_SXY,
      N_REACH,
      N_AX,
      N_AY,
      N_AZ,
      N_SAX,
      N_SAY,
      N_SCALE,
      N_NORM,
      N_NX,
      N_NY,
      N_SQRT,
      N_DPREP,
      N_DLOAD,
      N_DIV,
      N_DONE
   } nav_state_type;

endpackage

`default_nettype wire

// ===== rtl/gvca_csr.sv =====
// Configuration register file of the goal velocity command arbiter.
`default_nettype none

module gvca_csr
   import gvca_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write index; each register keeps its own width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MODE_FLAGS:      cfg_in.mode_flags            = csr_wdata[1:0];
            REG_GAIN_XY:         cfg_in.gain_xy               = csr_wdata[15:0];
            REG_MAX_SPEED_XY:    cfg_in.max_speed_xy          = csr_wdata[20:0];
            REG_GAIN_Z:          cfg_in.gain_z                = csr_wdata[15:0];
            REG_MAX_SPEED_Z:     cfg_in.max_speed_z           = csr_wdata[20:0];
            REG_REACH_RADIUS_XY: cfg_in.reach_radius_xy       = csr_wdata[20:0];
            REG_REACH_RADIUS_Z:  cfg_in.reach_radius_z        = csr_wdata[20:0];
            REG_PLANNER_TIMEOUT: cfg_in.planner_timeout_ticks = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/gvca_nav.sv =====
// Goal navigation sequencer around one shared multiplier, adder and comparator.
`default_nettype none

module gvca_nav
   import gvca_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  cfg_type        cfg,
   input  vec3_type       goal,
   input  vec3_type       pose,
   output logic           done,
   output nav_result_type result
);

   nav_state_type state_ff;
   nav_state_type state_in;

   logic [63:0] prod_ff;
   logic [63:0] acc_ff;
   logic [63:0] root_ff;
   logic [62:0] bit_ff;
   logic [41:0] r2_ff;
   logic [31:0] mx_ff;
   logic [31:0] my_ff;
   logic [31:0] mz_ff;
   logic        negx_ff;
   logic        negy_ff;
   logic        negz_ff;
   logic        reached_ff;
   logic [39:0] ax_ff;
   logic [39:0] ay_ff;
   logic [20:0] az_ff;
   logic [39:0] bx_ff;
   logic [39:0] by_ff;
   logic [54:0] rem_ff;
   logic [54:0] ds_ff;
   logic [21:0] q_ff;
   logic [4:0]  cnt_ff;
   logic        comp_ff;

   // Shared arithmetic unit operands.
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;
   logic [63:0] add_a;
   logic [63:0] add_b;
   logic [63:0] add_y;
   logic [63:0] cmp_a;
   logic [63:0] cmp_b;
   logic [64:0] cmp_d;
   logic        cmp_ge;

   logic [32:0] dmx;
   logic [32:0] dmy;
   logic [32:0] dmz;
   logic [39:0] big_w;
   logic [39:0] rnd_w;
   logic [20:0] az_clamp;
   logic        ax_big;
   logic        reach_hit;
   logic        scale_w;
   logic        norm_ok;
   logic [21:0] q_next;

   // Goal minus pose, saturated to 32 bits; returns sign and magnitude.
   function automatic logic [32:0] sat_diff_mag(input logic [31:0] g, input logic [31:0] p);
      logic [32:0] d;
      logic [31:0] s;
      d = {g[31], g} - {p[31], p};
      if (d[32] != d[31]) begin
         s = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         s = d[31:0];
      end
      return {s[31], s[31] ? (~s + 32'd1) : s};
   endfunction

   assign mul_p  = mul_a * mul_b;
   assign add_y  = add_a + add_b;
   assign cmp_d  = {1'b0, cmp_a} - {1'b0, cmp_b};
   assign cmp_ge = ~cmp_d[64];

   // Per-axis differences and the small decisions of the sequence.
   assign dmx       = sat_diff_mag(goal[0], pose[0]);
   assign dmy       = sat_diff_mag(goal[1], pose[1]);
   assign dmz       = sat_diff_mag(goal[2], pose[2]);
   assign big_w     = (bx_ff >= by_ff) ? bx_ff : by_ff;
   assign norm_ok   = (big_w[39:31] == 9'd0) && big_w[30];
   assign rnd_w     = add_y[47:8];
   assign az_clamp  = (rnd_w > {19'd0, cfg.max_speed_z}) ? cfg.max_speed_z : rnd_w[20:0];
   assign ax_big    = (|ax_ff[39:21]) || (|ay_ff[39:21]);
   assign reach_hit = ~cmp_ge && (mz_ff < {11'd0, cfg.reach_radius_z});
   assign scale_w   = ax_big || ~cmp_ge;
   assign q_next    = {q_ff[20:0], cmp_ge};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         N_IDLE:  if (start) state_in = N_DIFF;
         N_DIFF:  state_in = N_R2;
         N_R2:    state_in = N_MX;
         N_MX:    state_in = N_MY;
         N_MY:    state_in = N_SXY;
         N_SXY:   state_in = N_REACH;
         N_REACH: state_in = reach_hit ? N_DONE : N_AX;
         N_AX:    state_in = N_AY;
         N_AY:    state_in = N_AZ;
         N_AZ:    state_in = N_SAX;
         N_SAX:   state_in = N_SAY;
         N_SAY:   state_in = N_SCALE;
         N_SCALE: state_in = scale_w ? N_NORM : N_DONE;
         N_NORM:  if (norm_ok) state_in = N_NX;
         N_NX:    state_in = N_NY;
         N_NY:    state_in = N_SQRT;
         N_SQRT:  if (cnt_ff == 5'd0) state_in = N_DPREP;
         N_DPREP: state_in = N_DLOAD;
         N_DLOAD: state_in = N_DIV;
         N_DIV: begin
            if (cnt_ff == 5'd0) begin
               state_in = comp_ff ? N_DONE : N_DLOAD;
            end
         end
         N_DONE:  state_in = N_IDLE;
         default: state_in = N_IDLE;
      endcase
   end

   // Operand selection for the shared units, and the done strobe.
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      add_a = 64'd0;
      add_b = 64'd0;
      cmp_a = 64'd0;
      cmp_b = 64'd0;
      done  = (state_ff == N_DONE);
      unique case (state_ff)
         N_R2: begin
            mul_a = {11'd0, cfg.reach_radius_xy};
            mul_b = {11'd0, cfg.reach_radius_xy};
         end
         N_MX: begin
            mul_a = mx_ff;
            mul_b = mx_ff;
         end
         N_MY: begin
            mul_a = my_ff;
            mul_b = my_ff;
         end
         N_SXY: begin
            add_a = acc_ff;
            add_b = prod_ff;
         end
         N_REACH: begin
            cmp_a = acc_ff;
            cmp_b = {22'd0, r2_ff};
            mul_a = {16'd0, cfg.gain_xy};
            mul_b = mx_ff;
         end
         N_AX: begin
            add_a = prod_ff;
            add_b = 64'd128;
            mul_a = {16'd0, cfg.gain_xy};
            mul_b = my_ff;
         end
         N_AY: begin
            add_a = prod_ff;
            add_b = 64'd128;
            mul_a = {16'd0, cfg.gain_z};
            mul_b = mz_ff;
         end
         N_AZ: begin
            add_a = prod_ff;
            add_b = 64'd128;
            mul_a = ax_ff[31:0];
            mul_b = ax_ff[31:0];
         end
         N_SAX: begin
            mul_a = ay_ff[31:0];
            mul_b = ay_ff[31:0];
         end
         N_SAY: begin
            add_a = acc_ff;
            add_b = prod_ff;
            mul_a = {11'd0, cfg.max_speed_xy};
            mul_b = {11'd0, cfg.max_speed_xy};
         end
         N_SCALE: begin
            cmp_a = prod_ff;
            cmp_b = acc_ff;
         end
         N_NORM: begin
            mul_a = bx_ff[31:0];
            mul_b = bx_ff[31:0];
         end
         N_NX: begin
            mul_a = by_ff[31:0];
            mul_b = by_ff[31:0];
         end
         N_NY: begin
            add_a = acc_ff;
            add_b = prod_ff;
         end
         N_SQRT: begin
            add_a = root_ff;
            add_b = {1'b0, bit_ff};
            cmp_a = acc_ff;
            cmp_b = add_y;
         end
         N_DPREP: begin
            mul_a = {11'd0, cfg.max_speed_xy};
            mul_b = bx_ff[31:0];
         end
         N_DLOAD: begin
            add_a = {prod_ff[62:0], 1'b0};
            add_b = {32'd0, root_ff[31:0]};
         end
         N_DIV: begin
            cmp_a = {9'd0, rem_ff};
            cmp_b = {9'd0, ds_ff};
            mul_a = {11'd0, cfg.max_speed_xy};
            mul_b = by_ff[31:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers; the multiplier product is captured every cycle.
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      case (state_ff)
         N_DIFF: begin
            {negx_ff, mx_ff} <= dmx;
            {negy_ff, my_ff} <= dmy;
            {negz_ff, mz_ff} <= dmz;
            reached_ff       <= 1'b0;
         end
         N_MX:    r2_ff <= prod_ff[41:0];
         N_MY:    acc_ff <= prod_ff;
         N_SXY:   acc_ff <= add_y;
         N_REACH: reached_ff <= reach_hit;
         N_AX:    ax_ff <= rnd_w;
         N_AY:    ay_ff <= rnd_w;
         N_AZ:    az_ff <= az_clamp;
         N_SAX:   acc_ff <= prod_ff;
         N_SAY:   acc_ff <= add_y;
         N_SCALE: begin
            bx_ff <= ax_ff;
            by_ff <= ay_ff;
         end
         // Bring the larger component into [2^30, 2^31) by a common shift.
         N_NORM: begin
            if (big_w[39:31] != 9'd0) begin
               bx_ff <= bx_ff >> 1;
               by_ff <= by_ff >> 1;
            end else if (big_w[30:26] == 5'd0) begin
               bx_ff <= bx_ff << 4;
               by_ff <= by_ff << 4;
            end else if (!big_w[30]) begin
               bx_ff <= bx_ff << 1;
               by_ff <= by_ff << 1;
            end
         end
         N_NX: acc_ff <= prod_ff;
         N_NY: begin
            acc_ff  <= add_y;
            root_ff <= 64'd0;
            bit_ff  <= {1'b1, 62'd0};
            cnt_ff  <= 5'd31;
         end
         // One root step per cycle, the radicand remainder kept in acc.
         N_SQRT: begin
            if (cmp_ge) begin
               acc_ff  <= cmp_d[63:0];
               root_ff <= (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff - 5'd1;
         end
         N_DPREP: comp_ff <= 1'b0;
         N_DLOAD: begin
            rem_ff <= add_y[54:0];
            ds_ff  <= {1'b0, root_ff[31:0], 22'd0};
            q_ff   <= 22'd0;
            cnt_ff <= 5'd21;
         end
         // Restoring division, one quotient bit per cycle.
         N_DIV: begin
            if (cmp_ge) begin
               rem_ff <= cmp_d[54:0];
            end
            q_ff   <= q_next;
            ds_ff  <= ds_ff >> 1;
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               if (!comp_ff) begin
                  ax_ff   <= {18'd0, q_next};
                  comp_ff <= 1'b1;
               end else begin
                  ay_ff <= {18'd0, q_next};
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign result = '{
      reached: reached_ff,
      neg_x:   negx_ff,
      neg_y:   negy_ff,
      neg_z:   negz_ff,
      mag_x:   ax_ff[31:0],
      mag_y:   ay_ff[31:0],
      mag_z:   {11'd0, az_ff}
   };

   // A pass is only started while the sequencer is idle.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == N_IDLE)
      else $error("navigation started while busy");

   // Moving commands never exceed the speed limit range.
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      (done && !result.reached) |->
         (result.mag_x[31:22] == 10'd0) && (result.mag_y[31:22] == 10'd0)
         && (result.mag_z[31:21] == 11'd0))
      else $error("navigation magnitude out of range");

   // After normalization the norm lies in [2^30, 2^32), so the divisor is nonzero.
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == N_DLOAD |-> (root_ff[63:32] == 32'd0) && (root_ff[31:30] != 2'd0))
      else $error("norm outside normalized range");

endmodule

`default_nettype wire

// ===== rtl/goal_velocity_command_arbiter.sv =====
// Top level of the goal velocity command arbiter: state, arbitration and result register.
//
//   channel   ports                           direction  payload
//   req       req_valid/req_ready/req_data    in         req_type (pose, goal, planner, tick)
//   rsp       rsp_valid/rsp_ready/rsp_data    out        rsp_type (velocity command, source)
//   csr       csr_we/csr_index/csr_wdata      in         one register per write, no read-back
//
// Pose, goal and planner transactions and non-navigating ticks bypass the sequencer. A
// tick that navigates runs the shared multiplier sequence, which ends early when the goal
// is reached or needs no xy scaling; with scaling it adds normalizing shifts, a 32-step
// one-bit-per-cycle square root and two 22-step divisions.
// Reset is synchronous and restores the register defaults and the goal at 5 m height.
// req_ready is low while navigating and while a result waits with rsp_ready low.
`default_nettype none

module goal_velocity_command_arbiter
   import gvca_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type        cfg;
   nav_result_type nav_result;
   logic           nav_start;
   logic           nav_done;

   top_state_type  t_state_ff;
   top_state_type  t_state_in;

   logic           pose_seen_ff;
   vec3_type       pose_ff;
   vec3_type       goal_ff;
   logic           planner_seen_ff;
   logic [3:0][31:0] planner_ff;
   logic [15:0]    age_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_type        rsp_data_ff;

   logic           req_accept;
   logic           tick_accept;
   logic           fresh;
   logic           nav_en;
   logic           load_fwd;
   logic           load_hb;

   function automatic logic [31:0] apply_sign(input logic [31:0] m, input logic neg);
      return neg ? (32'd0 - m) : m;
   endfunction

   gvca_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gvca_nav u_nav (
      .clock  (clock),
      .reset  (reset),
      .start  (nav_start),
      .cfg    (cfg),
      .goal   (goal_ff),
      .pose   (pose_ff),
      .done   (nav_done),
      .result (nav_result)
   );

   assign req_accept  = req_valid && req_ready;
   assign tick_accept = req_accept && (req_data.action == ACT_TICK);
   assign fresh       = planner_seen_ff && (age_ff <= cfg.planner_timeout_ticks);
   assign nav_en      = cfg.mode_flags[MODE_NAV_EN_BIT];

   // Next state.
   always_comb begin
      t_state_in = t_state_ff;
      unique case (t_state_ff)
         T_IDLE: if (nav_start) t_state_in = T_NAV;
         T_NAV:  if (nav_done) t_state_in = T_IDLE;
         default: t_state_in = T_IDLE;
      endcase
   end

   // Handshake and the choice of what a tick emits.
   always_comb begin
      req_ready = (t_state_ff == T_IDLE) && (!rsp_valid_ff || rsp_ready);
      nav_start = tick_accept && pose_seen_ff && !fresh && nav_en;
      load_fwd  = tick_accept && pose_seen_ff && fresh;
      load_hb   = tick_accept && pose_seen_ff && !fresh && !nav_en
                  && (cfg.mode_flags[MODE_HEARTBEAT_BIT] || !req_data.armed_offboard);
      if (load_fwd || load_hb || nav_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         t_state_ff      <= T_IDLE;
         rsp_valid_ff    <= 1'b0;
         pose_seen_ff    <= 1'b0;
         planner_seen_ff <= 1'b0;
         age_ff          <= 16'd0;
         goal_ff         <= {GOAL_Z_RESET, 32'd0, 32'd0};
      end else begin
         t_state_ff   <= t_state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            case (req_data.action)
               ACT_POSE: pose_seen_ff <= 1'b1;
               ACT_GOAL: goal_ff <= {req_data.val_z, req_data.val_y, req_data.val_x};
               ACT_PLANNER: begin
                  planner_seen_ff <= 1'b1;
                  age_ff          <= 16'd0;
               end
               default: begin
                  if (age_ff != AGE_MAX) age_ff <= age_ff + 16'd1;
               end
            endcase
         end
      end
   end

   // Stored pose and planner command.
   always_ff @(posedge clock) begin
      if (req_accept && (req_data.action == ACT_POSE)) begin
         pose_ff <= {req_data.val_z, req_data.val_y, req_data.val_x};
      end
      if (req_accept && (req_data.action == ACT_PLANNER)) begin
         planner_ff <= {req_data.val_yaw_rate, req_data.val_z, req_data.val_y,
                        req_data.val_x};
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load_fwd) begin
         rsp_data_ff.cmd_vx       <= planner_ff[0];
         rsp_data_ff.cmd_vy       <= planner_ff[1];
         rsp_data_ff.cmd_vz       <= planner_ff[2];
         rsp_data_ff.cmd_yaw_rate <= planner_ff[3];
         rsp_data_ff.cmd_source   <= SRC_PLANNER;
      end else if (load_hb) begin
         rsp_data_ff.cmd_vx       <= 32'sd0;
         rsp_data_ff.cmd_vy       <= 32'sd0;
         rsp_data_ff.cmd_vz       <= 32'sd0;
         rsp_data_ff.cmd_yaw_rate <= 32'sd0;
         rsp_data_ff.cmd_source   <= SRC_HEARTBEAT;
      end else if (nav_done) begin
         rsp_data_ff.cmd_yaw_rate <= 32'sd0;
         if (nav_result.reached) begin
            rsp_data_ff.cmd_vx     <= 32'sd0;
            rsp_data_ff.cmd_vy     <= 32'sd0;
            rsp_data_ff.cmd_vz     <= 32'sd0;
            rsp_data_ff.cmd_source <= SRC_GOAL_HOLD;
         end else begin
            rsp_data_ff.cmd_vx     <= apply_sign(nav_result.mag_x, nav_result.neg_x);
            rsp_data_ff.cmd_vy     <= apply_sign(nav_result.mag_y, nav_result.neg_y);
            rsp_data_ff.cmd_vz     <= apply_sign(nav_result.mag_z, nav_result.neg_z);
            rsp_data_ff.cmd_source <= SRC_GOAL_NAV;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The result register is empty for the whole navigation pass.
   a_nav_empty: assert property (@(posedge clock) disable iff (reset)
      t_state_ff == T_NAV |-> !rsp_valid_ff)
      else $error("result pending during navigation");

   // Navigation completes only while the arbiter waits for it.
   a_done_in_nav: assert property (@(posedge clock) disable iff (reset)
      nav_done |-> t_state_ff == T_NAV)
      else $error("navigation done outside a navigation pass");

   // A fresh planner command is forwarded in the next cycle.
   a_forward: assert property (@(posedge clock) disable iff (reset)
      (tick_accept && pose_seen_ff && fresh) |=>
         rsp_valid_ff && (rsp_data_ff.cmd_source == SRC_PLANNER))
      else $error("fresh planner command not forwarded");

endmodule

`default_nettype wire
